// ===== rtl/core/via_pkg.sv =====
package via_pkg;

    // operation codes carried on the slave tuser
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_READ   = 3'd1;
    localparam logic [2:0] FUNC_WRITE  = 3'd2;
    localparam logic [2:0] FUNC_SHIFT  = 3'd3;
    localparam logic [2:0] FUNC_SECOND = 3'd4;

    // register map
    localparam logic [3:0] REG_BUFB   = 4'd0;
    localparam logic [3:0] REG_DIRB   = 4'd2;
    localparam logic [3:0] REG_DIRA   = 4'd3;
    localparam logic [3:0] REG_T1CL   = 4'd4;
    localparam logic [3:0] REG_T1CH   = 4'd5;
    localparam logic [3:0] REG_T1LL   = 4'd6;
    localparam logic [3:0] REG_T1LH   = 4'd7;
    localparam logic [3:0] REG_T2CL   = 4'd8;
    localparam logic [3:0] REG_T2CH   = 4'd9;
    localparam logic [3:0] REG_SR     = 4'd10;
    localparam logic [3:0] REG_ACR    = 4'd11;
    localparam logic [3:0] REG_PCR    = 4'd12;
    localparam logic [3:0] REG_IFR    = 4'd13;
    localparam logic [3:0] REG_IER    = 4'd14;
    localparam logic [3:0] REG_BUFA   = 4'd15;

    // interrupt flag bits and masks
    localparam logic [6:0] FLAG_T1        = 7'h40;
    localparam logic [6:0] FLAG_T2        = 7'h20;
    localparam logic [6:0] FLAG_SR        = 7'h04;
    localparam logic [6:0] FLAG_SEC       = 7'h01;
    localparam logic [6:0] KEEP_ON_PORTB  = 7'h67;
    localparam logic [6:0] KEEP_ON_PORTA  = 7'h7C;
    localparam logic [7:0] PORTB_FIXED    = 8'h38;
    localparam logic [7:0] PORTB_HBLANK   = 8'h40;
    localparam logic [7:0] PORTB_CLOCK    = 8'h07;
    localparam logic [7:0] PORTB_ALWAYS   = 8'h08;

    typedef struct packed {
        logic       shift_bit;
        logic [7:0] port_b_pins;
        logic [7:0] port_a_pins;
        logic [7:0] write_data;
        logic [3:0] reg_index;
        logic [2:0] func;
    } via_item_t;

    typedef struct packed {
        logic [7:0] port_b_drive;
        logic       head_select;
        logic       boot_overlay;
        logic       sound_out;
        logic       irq;
        logic       read_handled;
        logic [7:0] read_data;
    } via_result_t;

endpackage

// ===== rtl/core/via_in_stage.sv =====
module via_in_stage
    import via_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  via_item_t  in_item,
    input  logic       advance,
    output logic       item_valid,
    output via_item_t  item
);

    logic      valid_reg;
    logic      valid_next;
    via_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/via_core.sv =====
module via_core
    import via_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  via_item_t   item,
    output via_result_t result,
    output logic        irq_level
);

    logic [6:0]  flags_reg, flags_next;
    logic [6:0]  en_reg, en_next;
    logic [7:0]  dir_a_reg, dir_a_next;
    logic [7:0]  dir_b_reg, dir_b_next;
    logic [7:0]  out_a_reg, out_a_next;
    logic [7:0]  out_b_reg, out_b_next;
    logic [15:0] t1_cnt_reg, t1_cnt_next;
    logic [15:0] t1_lat_reg, t1_lat_next;
    logic [15:0] t2_cnt_reg, t2_cnt_next;
    logic [15:0] t2_lat_reg, t2_lat_next;
    logic        t1_run_reg, t1_run_next;
    logic        t2_run_reg, t2_run_next;
    logic [7:0]  sr_reg, sr_next;
    logic [2:0]  sr_cnt_reg, sr_cnt_next;
    logic [7:0]  acr_reg, acr_next;
    logic [7:0]  pcr_reg, pcr_next;
    logic        sound_reg, sound_next;

    logic [7:0]  rd;
    logic        rd_ok;
    logic [7:0]  inmask;
    logic [7:0]  ea_now;
    logic [7:0]  ea_after;
    logic        pb7_sound;

    assign inmask    = ~dir_b_reg;
    assign ea_now    = (out_a_reg & dir_a_reg) | (item.port_a_pins & ~dir_a_reg);
    assign pb7_sound = acr_reg[7] & dir_b_reg[7];

    always_comb
    begin
        flags_next  = flags_reg;
        en_next     = en_reg;
        dir_a_next  = dir_a_reg;
        dir_b_next  = dir_b_reg;
        out_a_next  = out_a_reg;
        out_b_next  = out_b_reg;
        t1_cnt_next = t1_cnt_reg;
        t1_lat_next = t1_lat_reg;
        t2_cnt_next = t2_cnt_reg;
        t2_lat_next = t2_lat_reg;
        t1_run_next = t1_run_reg;
        t2_run_next = t2_run_reg;
        sr_next     = sr_reg;
        sr_cnt_next = sr_cnt_reg;
        acr_next    = acr_reg;
        pcr_next    = pcr_reg;
        sound_next  = sound_reg;
        rd          = 8'h00;
        rd_ok       = 1'b0;

        if (fire)
        begin
            case (item.func)
                FUNC_TICK:
                begin
                    if (t1_run_reg)
                    begin
                        if (t1_cnt_reg == 16'h0000)
                        begin
                            if (pb7_sound)
                            begin
                                sound_next = 1'b1;
                            end
                            flags_next = flags_next | FLAG_T1;
                            if (acr_reg[6])
                            begin
                                t1_cnt_next = t1_lat_reg;
                            end
                            else
                            begin
                                t1_run_next = 1'b0;
                            end
                        end
                        else
                        begin
                            t1_cnt_next = t1_cnt_reg - 16'd1;
                        end
                    end
                    if (t2_run_reg && (t2_cnt_reg == 16'h0000))
                    begin
                        flags_next  = flags_next | FLAG_T2;
                        t2_run_next = 1'b0;
                    end
                    t2_cnt_next = t2_cnt_reg - 16'd1;
                end
                FUNC_READ:
                begin
                    rd_ok = 1'b1;
                    case (item.reg_index)
                        REG_BUFB:
                        begin
                            flags_next = flags_reg & KEEP_ON_PORTB;
                            rd = ({sound_reg, 7'b0} & inmask)
                               | (item.port_b_pins & PORTB_HBLANK & inmask)
                               | (item.port_b_pins & PORTB_CLOCK & inmask)
                               | (out_b_reg & PORTB_FIXED)
                               | PORTB_ALWAYS
                               | (out_b_reg & dir_b_reg);
                        end
                        REG_DIRB: rd = dir_b_reg;
                        REG_DIRA: rd = dir_a_reg;
                        REG_T1CL:
                        begin
                            flags_next = flags_reg & ~FLAG_T1;
                            rd = t1_cnt_reg[7:0];
                        end
                        REG_T1CH: rd = t1_cnt_reg[15:8];
                        REG_T1LL: rd = t1_lat_reg[7:0];
                        REG_T1LH: rd = t1_lat_reg[15:8];
                        REG_T2CL:
                        begin
                            flags_next = flags_reg & ~FLAG_T2;
                            rd = t2_cnt_reg[7:0];
                        end
                        REG_T2CH: rd = t2_cnt_reg[15:8];
                        REG_SR:
                        begin
                            flags_next = flags_reg & ~FLAG_SR;
                            rd = sr_reg;
                        end
                        REG_ACR: rd = acr_reg;
                        REG_PCR: rd = pcr_reg;
                        REG_IFR: rd = (flags_reg != 7'h00) ? {1'b1, flags_reg} : 8'h00;
                        REG_IER: rd = {1'b1, en_reg};
                        REG_BUFA:
                        begin
                            flags_next = flags_reg & KEEP_ON_PORTA;
                            rd = {1'b1, out_a_reg[6:5], ea_now[4], out_a_reg[3:0]};
                        end
                        default:
                        begin
                            rd_ok = 1'b0;
                        end
                    endcase
                end
                FUNC_WRITE:
                begin
                    case (item.reg_index)
                        REG_BUFB:
                        begin
                            flags_next = flags_reg & KEEP_ON_PORTB;
                            out_b_next = item.write_data;
                            sound_next = item.write_data[7] & dir_b_reg[7];
                        end
                        REG_DIRB:
                        begin
                            dir_b_next = item.write_data;
                            sound_next = out_b_reg[7] & item.write_data[7];
                        end
                        REG_DIRA: dir_a_next = item.write_data;
                        REG_T1CL, REG_T1LL: t1_lat_next = {t1_lat_reg[15:8], item.write_data};
                        REG_T1CH:
                        begin
                            flags_next  = flags_reg & ~FLAG_T1;
                            t1_lat_next = {item.write_data, t1_lat_reg[7:0]};
                            t1_cnt_next = {item.write_data, t1_lat_reg[7:0]};
                            t1_run_next = 1'b1;
                            if (pb7_sound)
                            begin
                                sound_next = 1'b0;
                            end
                        end
                        REG_T1LH: t1_lat_next = {item.write_data, t1_lat_reg[7:0]};
                        REG_T2CL: t2_lat_next = {t2_lat_reg[15:8], item.write_data};
                        REG_T2CH:
                        begin
                            flags_next  = flags_reg & ~FLAG_T2;
                            t2_lat_next = {item.write_data, t2_lat_reg[7:0]};
                            t2_cnt_next = {item.write_data, t2_lat_reg[7:0]};
                            t2_run_next = 1'b1;
                        end
                        REG_SR:
                        begin
                            flags_next = flags_reg & ~FLAG_SR;
                            sr_next    = item.write_data;
                        end
                        REG_ACR: acr_next = item.write_data;
                        REG_PCR: pcr_next = item.write_data;
                        REG_IFR: flags_next = flags_reg & ~item.write_data[6:0];
                        REG_IER:
                        begin
                            if (item.write_data[7])
                            begin
                                en_next = en_reg | item.write_data[6:0];
                            end
                            else
                            begin
                                en_next = en_reg & ~item.write_data[6:0];
                            end
                        end
                        REG_BUFA:
                        begin
                            flags_next = flags_reg & KEEP_ON_PORTA;
                            out_a_next = item.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_SHIFT:
                begin
                    sr_next = {item.shift_bit, sr_reg[7:1]};
                    if (sr_cnt_reg == 3'd7)
                    begin
                        sr_cnt_next = 3'd0;
                        flags_next  = flags_reg | FLAG_SR;
                    end
                    else
                    begin
                        sr_cnt_next = sr_cnt_reg + 3'd1;
                    end
                end
                FUNC_SECOND: flags_next = flags_reg | FLAG_SEC;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg  <= '0;
            en_reg     <= '0;
            dir_a_reg  <= '0;
            dir_b_reg  <= '0;
            out_a_reg  <= '0;
            out_b_reg  <= '0;
            t1_cnt_reg <= '0;
            t1_lat_reg <= '0;
            t2_cnt_reg <= '0;
            t2_lat_reg <= '0;
            t1_run_reg <= 1'b0;
            t2_run_reg <= 1'b0;
            sr_reg     <= '0;
            sr_cnt_reg <= '0;
            acr_reg    <= '0;
            pcr_reg    <= '0;
            sound_reg  <= 1'b0;
        end
        else
        begin
            flags_reg  <= flags_next;
            en_reg     <= en_next;
            dir_a_reg  <= dir_a_next;
            dir_b_reg  <= dir_b_next;
            out_a_reg  <= out_a_next;
            out_b_reg  <= out_b_next;
            t1_cnt_reg <= t1_cnt_next;
            t1_lat_reg <= t1_lat_next;
            t2_cnt_reg <= t2_cnt_next;
            t2_lat_reg <= t2_lat_next;
            t1_run_reg <= t1_run_next;
            t2_run_reg <= t2_run_next;
            sr_reg     <= sr_next;
            sr_cnt_reg <= sr_cnt_next;
            acr_reg    <= acr_next;
            pcr_reg    <= pcr_next;
            sound_reg  <= sound_next;
        end
    end

    // outputs reflect the state after this transaction
    assign ea_after = (out_a_next & dir_a_next) | (item.port_a_pins & ~dir_a_next);

    assign result.read_data    = rd;
    assign result.read_handled = rd_ok;
    assign result.irq          = |(en_next & flags_next);
    assign result.sound_out    = sound_next;
    assign result.boot_overlay = ea_after[4];
    assign result.head_select  = ea_after[5];
    assign result.port_b_drive = out_b_next & dir_b_next;

    assign irq_level = |(en_reg & flags_reg);

endmodule

// ===== rtl/core/versatile_interface_timer_irq.sv =====
// channel   dir  payload                                              last  kind
// s_*       in   tdata: reg_index, write_data, port_a_pins,            -     tuser: func
//                 port_b_pins, shift_bit (32 bits)
// m_*       out  tdata: read_data, read_handled, irq, sound_out,       -     -
//                 boot_overlay, head_select, port_b_drive (24 bits)
//
// one transaction per clock sustained while m_tready is high; m_tvalid rises after the s_* accept,
// once the item has passed the input register, then the update logic into the result register
// rst_n is asynchronous, clears the adapter state and both valid flags
// a stalled m_tready holds the result; the input register still takes one more
// transaction, after which s_tready drops until the result is taken
module versatile_interface_timer_irq
    import via_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // reg_index[3:0], write_data[11:4], port_a_pins[19:12],
                                   // port_b_pins[27:20], shift_bit[28], zero fill
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // read_data[7:0], read_handled[8], irq[9], sound_out[10],
                                   // boot_overlay[11], head_select[12], port_b_drive[20:13]
);

    via_item_t   in_item;
    via_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        fire;
    via_result_t result;
    via_result_t res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        irq_level;

    // unpack the incoming transaction
    assign in_item.func        = s_tuser;
    assign in_item.reg_index   = s_tdata[3:0];
    assign in_item.write_data  = s_tdata[11:4];
    assign in_item.port_a_pins = s_tdata[19:12];
    assign in_item.port_b_pins = s_tdata[27:20];
    assign in_item.shift_bit   = s_tdata[28];

    // the result register can take a new value when empty or being drained
    assign advance = !res_valid_reg || m_tready;
    assign fire    = item_valid && advance;

    via_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    via_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .result    (result),
        .irq_level (irq_level)
    );

    assign res_valid_next = advance ? item_valid : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    // an empty result register never back-pressures the input side
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // every processed transaction shows up as a result next cycle
    a_fire_to_result : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("processed transaction lost");

    // the irq bit of a fresh result matches the live interrupt state
    a_irq_matches : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (res_reg.irq == irq_level))
        else $error("irq result differs from flag and enable state");

    // a drained result with nothing behind it leaves the output empty
    a_drain_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !item_valid) |=> !m_tvalid)
        else $error("result repeated after being taken");

endmodule
